// ----- rtl/core/mqbb_pkg.sv -----
// Shared types and constants for the mesh quad bounding box unit.
package mqbb_pkg;
	localparam int MaxColumns = 256;
	localparam int LineDepth = MaxColumns - 1;
	localparam int ColW = $clog2(MaxColumns);
	localparam int DivSteps = 48;
	localparam int DivCntW = $clog2(DivSteps + 1);

	localparam logic CfgColumns = 1'b0;
	localparam logic CfgRows = 1'b1;

	localparam logic KindCell = 1'b0;
	localparam logic KindMesh = 1'b1;

	typedef struct packed {
		logic signed [31:0] lo_x;
		logic signed [31:0] lo_y;
		logic signed [31:0] hi_x;
		logic signed [31:0] hi_y;
	} box_t;

	typedef struct packed {
		logic            start;     // launch both dividers
		logic            merge;     // commit quotients into the boxes
		logic            load_cell; // move cell box into the output register
		logic            load_mesh; // move mesh box into the output register
		logic            first;
		logic            has_edge;
		logic            wr_line;
		logic [15:0]     row;
		logic [ColW-1:0] col;
	} mqbb_cmd_t;

	typedef struct packed {
		logic div_done;
	} mqbb_stat_t;
endpackage

// ----- rtl/core/mesh_quad_bounding_boxes_unit.sv -----
// Top level of the mesh quad bounding box unit.
//  channel  direction  handshake             payload
//  in       input      in_valid/in_ready     pos_x, pos_y, pos_z
//  out      output     out_valid/out_ready   box_*, box_kind, cell_row, cell_col, divide_fault, last
//  cfg      input      cfg_valid/cfg_ready   cfg_index, cfg_data
// A vertex that gives a cell box goes through accept, the two bit-serial dividers running
// side by side and their done flag, merge and one output load.
// A vertex with no cell box skips the load; a mesh-end vertex adds a mesh box load.
// Reset returns counters and the mesh box to zero, grid to 2 by 2; the cell box, output and line store are not cleared.
// A stalled output holds the unit in its load state; no new vertex is taken until that load.
module mesh_quad_bounding_boxes_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] box_min_x,
	output logic signed [31:0] box_min_y,
	output logic signed [31:0] box_max_x,
	output logic signed [31:0] box_max_y,
	output logic               box_kind,
	output logic [15:0]        cell_row,
	output logic [7:0]         cell_col,
	output logic               divide_fault,
	output logic               last,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data
);
	import mqbb_pkg::*;

	mqbb_cmd_t cmd;
	mqbb_stat_t stat;

	mqbb_ctrl u_ctrl (.clk, .arst_n, .in_valid, .in_ready, .out_ready, .out_valid,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .stat, .cmd);

	mqbb_datapath u_dp (.clk, .arst_n, .cmd, .stat, .pos_x, .pos_y, .pos_z,
		.box_min_x, .box_min_y, .box_max_x, .box_max_y, .box_kind, .cell_row,
		.cell_col, .divide_fault, .last);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken during division");

	a_last_is_mesh: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> box_kind && cell_row == 16'd0 && cell_col == 8'd0)
		else $error("last item is not the mesh box");

	a_no_load_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !cmd.merge && !cmd.load_cell && !cmd.load_mesh)
		else $error("overlapping commands");
endmodule

// ----- rtl/core/mqbb_div.sv -----
// Iterative Q16.16 divider with saturation, one quotient bit per cycle.
module mqbb_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] num,
	input  logic signed [31:0] den,
	output logic               done,
	output logic signed [31:0] quot,
	output logic               fault
);
	import mqbb_pkg::*;

	logic [47:0] work_q;
	logic [31:0] dmag_q;
	logic [31:0] rem_q;
	logic [DivCntW-1:0] cnt_q;
	logic busy_q, done_q, neg_q, zero_q, nneg_q, nzero_q;
	logic [32:0] rem_sh, rem_sub;
	logic qbit, over;
	logic [31:0] nabs, dabs;

	assign nabs = num[31] ? 32'(-num) : 32'(num);
	assign dabs = den[31] ? 32'(-den) : 32'(den);
	assign rem_sh = {rem_q, work_q[47]};
	assign rem_sub = rem_sh - {1'b0, dmag_q};
	assign qbit = !rem_sub[32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= DivCntW'(DivSteps);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DivCntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= {nabs, 16'h0};
			dmag_q <= dabs;
			rem_q <= '0;
			neg_q <= num[31] ^ den[31];
			zero_q <= (den == 32'sd0);
			nneg_q <= num[31];
			nzero_q <= (num == 32'sd0);
		end else if (busy_q) begin
			rem_q <= qbit ? rem_sub[31:0] : rem_sh[31:0];
			work_q <= {work_q[46:0], qbit};
		end
	end

	always_comb begin
		over = 1'b0;
		quot = '0;
		if (zero_q) begin
			over = 1'b1;
			quot = nzero_q ? 32'sh0 : (nneg_q ? 32'sh80000000 : 32'sh7fffffff);
		end else if (neg_q) begin
			over = (|work_q[47:32]) || (work_q[31] && (|work_q[30:0]));
			quot = over ? 32'sh80000000 : 32'(-work_q[31:0]);
		end else begin
			over = |work_q[47:31];
			quot = over ? 32'sh7fffffff : work_q[31:0];
		end
	end

	assign fault = over;
	assign done = done_q;
endmodule

// ----- rtl/core/mqbb_datapath.sv -----
// Datapath: projection dividers, edge line store, box merging, output register.
module mqbb_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  mqbb_pkg::mqbb_cmd_t cmd,
	output mqbb_pkg::mqbb_stat_t stat,
	input  logic signed [31:0]  pos_x,
	input  logic signed [31:0]  pos_y,
	input  logic signed [31:0]  pos_z,
	output logic signed [31:0]  box_min_x,
	output logic signed [31:0]  box_min_y,
	output logic signed [31:0]  box_max_x,
	output logic signed [31:0]  box_max_y,
	output logic                box_kind,
	output logic [15:0]         cell_row,
	output logic [7:0]          cell_col,
	output logic                divide_fault,
	output logic                last
);
	import mqbb_pkg::*;

	logic done_x, done_y, fault_x, fault_y;
	logic signed [31:0] px, py;
	logic signed [31:0] prev_x_q, prev_y_q;
	box_t line_mem [LineDepth];
	box_t line_rd_q, total_q, cell_q, out_q, eb, base, cell_d, tot_d;
	logic fault_q, kind_q, outf_q;
	logic [15:0] row_q, orow_q;
	logic [ColW-1:0] col_q, ocol_q;

	mqbb_div u_div_x (.clk, .arst_n, .start(cmd.start), .num(pos_x), .den(pos_z),
		.done(done_x), .quot(px), .fault(fault_x));
	mqbb_div u_div_y (.clk, .arst_n, .start(cmd.start), .num(pos_y), .den(pos_z),
		.done(done_y), .quot(py), .fault(fault_y));

	assign stat.div_done = done_x && done_y;

	function automatic box_t merge_box(box_t a, box_t b);
		box_t m;
		m.lo_x = (a.lo_x < b.lo_x) ? a.lo_x : b.lo_x;
		m.lo_y = (a.lo_y < b.lo_y) ? a.lo_y : b.lo_y;
		m.hi_x = (a.hi_x > b.hi_x) ? a.hi_x : b.hi_x;
		m.hi_y = (a.hi_y > b.hi_y) ? a.hi_y : b.hi_y;
		return m;
	endfunction

	always_comb begin
		eb.lo_x = (prev_x_q < px) ? prev_x_q : px;
		eb.hi_x = (prev_x_q < px) ? px : prev_x_q;
		eb.lo_y = (prev_y_q < py) ? prev_y_q : py;
		eb.hi_y = (prev_y_q < py) ? py : prev_y_q;
		base = cmd.first ? box_t'({px, py, px, py}) : total_q;
		tot_d = cmd.has_edge ? merge_box(base, eb) : base;
		cell_d = merge_box(line_rd_q, eb);
	end

	// Read address is held steady through the division, so data is ready at merge.
	always_ff @(posedge clk) begin
		line_rd_q <= line_mem[cmd.col];
		if (cmd.merge && cmd.wr_line)
			line_mem[cmd.col] <= eb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q <= '0;
			prev_y_q <= '0;
			total_q <= '0;
		end else if (cmd.merge) begin
			prev_x_q <= px;
			prev_y_q <= py;
			total_q <= tot_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.merge) begin
			cell_q <= cell_d;
			fault_q <= fault_x | fault_y;
			row_q <= cmd.row;
			col_q <= cmd.col;
		end
		if (cmd.load_cell) begin
			out_q <= cell_q;
			kind_q <= KindCell;
			orow_q <= row_q;
			ocol_q <= col_q;
			outf_q <= fault_q;
		end else if (cmd.load_mesh) begin
			out_q <= total_q;
			kind_q <= KindMesh;
			orow_q <= '0;
			ocol_q <= '0;
			outf_q <= fault_q;
		end
	end

	assign box_min_x = out_q.lo_x;
	assign box_min_y = out_q.lo_y;
	assign box_max_x = out_q.hi_x;
	assign box_max_y = out_q.hi_y;
	assign box_kind = kind_q;
	assign cell_row = orow_q;
	assign cell_col = 8'(ocol_q);
	assign divide_fault = outf_q;
	assign last = (kind_q == KindMesh);
endmodule

// ----- rtl/core/mqbb_ctrl.sv -----
// Controller: grid counters, configuration, sequencing and output handshake.
module mqbb_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 out_ready,
	output logic                 out_valid,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_index,
	input  logic [15:0]          cfg_data,
	input  mqbb_pkg::mqbb_stat_t stat,
	output mqbb_pkg::mqbb_cmd_t  cmd
);
	import mqbb_pkg::*;

	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StDiv = 3'd1;
	localparam logic [2:0] StMerge = 3'd2;
	localparam logic [2:0] StCell = 3'd3;
	localparam logic [2:0] StMesh = 3'd4;

	logic [2:0] state_q;
	logic [8:0] cols_q;
	logic [15:0] rows_q;
	logic [15:0] row_q;
	logic [ColW-1:0] col_q;
	logic [8:0] cols_last;
	logic [15:0] rows_last;
	logic row_end, mesh_end, accept, slot_free;
	logic first_q, edge_q, cell_q, wr_q, end_q;
	logic [15:0] crow_q;
	logic [ColW-1:0] ccol_q;
	logic out_valid_q;

	assign cfg_ready = 1'b1;
	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == StIdle);
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		if (cols_q < 9'd2) cols_last = 9'd1;
		else if (cols_q > 9'(MaxColumns)) cols_last = 9'(MaxColumns - 1);
		else cols_last = cols_q - 9'd1;
		rows_last = (rows_q == 16'd0) ? 16'd0 : rows_q - 16'd1;
		row_end = ({1'b0, col_q} >= cols_last);
		mesh_end = (row_q >= rows_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= 9'd2;
			rows_q <= 16'd2;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CfgColumns: cols_q <= cfg_data[8:0];
				CfgRows: rows_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_cell || cmd.load_mesh) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			row_q <= '0;
			col_q <= '0;
			first_q <= 1'b0;
			edge_q <= 1'b0;
			cell_q <= 1'b0;
			wr_q <= 1'b0;
			end_q <= 1'b0;
			crow_q <= '0;
			ccol_q <= '0;
		end else begin
			unique case (state_q)
				StIdle: begin
					if (accept) begin
						first_q <= (row_q == 16'd0) && (col_q == '0);
						edge_q <= (col_q != '0);
						cell_q <= (col_q != '0) && (row_q != 16'd0);
						wr_q <= (col_q != '0) && ((row_q == 16'd0) || (row_q < rows_last));
						end_q <= row_end && mesh_end;
						crow_q <= row_q - 16'd1;
						ccol_q <= col_q - 1'b1;
						// advance the grid position
						if (row_end) begin
							col_q <= '0;
							row_q <= mesh_end ? 16'd0 : row_q + 16'd1;
						end else begin
							col_q <= col_q + 1'b1;
						end
						state_q <= StDiv;
					end
				end
				StDiv: if (stat.div_done) state_q <= StMerge;
				StMerge: state_q <= cell_q ? StCell : (end_q ? StMesh : StIdle);
				StCell: begin
					if (slot_free)
						state_q <= end_q ? StMesh : StIdle;
				end
				StMesh: begin
					if (slot_free)
						state_q <= StIdle;
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	always_comb begin
		cmd.start = accept;
		cmd.merge = (state_q == StMerge);
		cmd.load_cell = (state_q == StCell) && slot_free;
		cmd.load_mesh = (state_q == StMesh) && slot_free;
		cmd.first = first_q;
		cmd.has_edge = edge_q;
		cmd.wr_line = wr_q;
		cmd.row = crow_q;
		cmd.col = ccol_q;
	end
endmodule
